@@ src/frp_pkg.sv @@
`default_nettype none

package frp_pkg;

    // Characters the parser reacts to
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Passive numbers saturate here; anything above 255 is an error
    localparam logic [8:0] NUM_LIMIT = 9'd256;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified request byte, as handed from front to back
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_space;
        logic       is_dash;
        logic       is_nl;
        logic       is_rparen;
        logic       is_comma;
    } frp_class_t;

    // Decimal accumulate with saturation at NUM_LIMIT
    function automatic logic [8:0] accumulate(input logic [8:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = {3'b000, acc} * 12'd10 + {8'h00, d};
        return (v > {3'b000, NUM_LIMIT}) ? NUM_LIMIT : v[8:0];
    endfunction

endpackage

`default_nettype wire

@@ src/frp_front.sv @@
`default_nettype none

// Front end: input handshake and character classification.
module frp_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_rx_byte,
    input  wire logic              q_full,
    output logic                   push,
    output frp_pkg::frp_class_t    push_cls
);

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        logic [7:0] dv;
        dv = s_rx_byte - frp_pkg::CH_ZERO;
        push_cls.is_digit  = (s_rx_byte >= frp_pkg::CH_ZERO) && (s_rx_byte <= frp_pkg::CH_NINE);
        push_cls.digit     = dv[3:0];
        push_cls.is_space  = (s_rx_byte == frp_pkg::CH_SPACE);
        push_cls.is_dash   = (s_rx_byte == frp_pkg::CH_DASH);
        push_cls.is_nl     = (s_rx_byte == frp_pkg::CH_NL);
        push_cls.is_rparen = (s_rx_byte == frp_pkg::CH_RPAREN);
        push_cls.is_comma  = (s_rx_byte == frp_pkg::CH_COMMA);
    end

endmodule

`default_nettype wire

@@ src/frp_queue.sv @@
`default_nettype none

// Two-entry queue of classified bytes between front and back.
module frp_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire frp_pkg::frp_class_t push_cls,
    output logic                     full,
    output logic                     q_valid,
    output frp_pkg::frp_class_t      q_cls,
    input  wire logic                pop
);

    frp_pkg::frp_class_t mem_reg [frp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'(frp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_cls   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cls;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(frp_pkg::QUEUE_DEPTH))
        else $error("queue holds more than its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ src/frp_back.sv @@
`default_nettype none

// Back end: parser state machine and result register.
module frp_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire logic                q_valid,
    input  wire frp_pkg::frp_class_t q_cls,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [9:0]               m_reply_code,
    output logic [15:0]              m_data_port,
    output logic                     m_parse_error
);

    typedef enum logic [8:0] {
        ST_WORD = 9'b000000001,  // first word / reply code
        ST_LINE = 9'b000000010,  // code mode: skip to newline
        ST_CONT = 9'b000000100,  // code mode: match continuation code
        ST_C1   = 9'b000001000,  // passive: comma count
        ST_C2   = 9'b000010000,
        ST_C3   = 9'b000100000,
        ST_C4   = 9'b001000000,
        ST_HIGH = 9'b010000000,  // passive: high number
        ST_LOW  = 9'b100000000   // passive: low number
    } frp_state_t;

    frp_state_t  state_reg, state_next;
    logic        passive_reg, passive_next;
    logic [2:0]  count_reg, count_next;
    logic [11:0] digits_reg, digits_next;
    logic [8:0]  high_reg, high_next;
    logic [8:0]  low_reg, low_next;

    logic        out_valid_reg, out_valid_next;
    logic [9:0]  out_code_reg, out_code_next;
    logic [15:0] out_port_reg, out_port_next;
    logic        out_err_reg, out_err_next;

    logic        emit;
    logic [9:0]  emit_code;
    logic [15:0] emit_port;
    logic        emit_err;
    logic [3:0]  cur_digit;
    logic [9:0]  code_val;

    assign pop = q_valid && (!out_valid_reg || m_ready);

    assign cur_digit = digits_reg[{count_reg[1:0], 2'b00} +: 4];
    assign code_val  = 10'(digits_reg[3:0]) * 10'd100 + 10'(digits_reg[7:4]) * 10'd10
                     + 10'(digits_reg[11:8]);

    always_comb begin
        state_next   = state_reg;
        passive_next = passive_reg;
        count_next   = count_reg;
        digits_next  = digits_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        emit         = 1'b0;
        emit_code    = '0;
        emit_port    = '0;
        emit_err     = 1'b0;

        if (cfg_wr_en) begin
            passive_next = cfg_wr_data;
            digits_next  = '0;
            state_next   = ST_WORD;
            count_next   = '0;
            high_next    = '0;
            low_next     = '0;
        end else if (pop) begin
            case (state_reg)
                ST_WORD: begin
                    if (q_cls.is_space) begin
                        count_next = '0;
                        if (count_reg != 3'd3) begin
                            emit     = 1'b1;
                            emit_err = 1'b1;
                            high_next = '0;
                            low_next  = '0;
                        end else begin
                            state_next = passive_reg ? ST_C1 : ST_LINE;
                        end
                    end else if (passive_reg) begin
                        if (count_reg != 3'd7) count_next = count_reg + 3'd1;
                    end else if (q_cls.is_dash) begin
                        count_next = '0;
                        state_next = ST_CONT;
                    end else if (q_cls.is_digit) begin
                        if (count_reg < 3'd3) begin
                            digits_next[{count_reg[1:0], 2'b00} +: 4] = q_cls.digit;
                        end
                        if (count_reg != 3'd7) count_next = count_reg + 3'd1;
                    end
                end
                ST_LINE: begin
                    if (q_cls.is_nl) begin
                        emit       = 1'b1;
                        emit_code  = code_val;
                        state_next = ST_WORD;
                        count_next = '0;
                        high_next  = '0;
                        low_next   = '0;
                    end
                end
                ST_CONT: begin
                    if (count_reg < 3'd3 && q_cls.is_digit && q_cls.digit == cur_digit) begin
                        count_next = count_reg + 3'd1;
                    end else if (count_reg == 3'd3 && q_cls.is_space) begin
                        count_next = '0;
                        state_next = ST_LINE;
                    end else begin
                        count_next = '0;  // mismatch restarts the match
                    end
                end
                ST_C1: if (q_cls.is_comma) state_next = ST_C2;
                ST_C2: if (q_cls.is_comma) state_next = ST_C3;
                ST_C3: if (q_cls.is_comma) state_next = ST_C4;
                ST_C4: if (q_cls.is_comma) state_next = ST_HIGH;
                ST_HIGH: begin
                    if (q_cls.is_comma) begin
                        count_next = '0;
                        state_next = ST_LOW;
                    end else if (q_cls.is_digit) begin
                        high_next = frp_pkg::accumulate(high_reg, q_cls.digit);
                    end
                end
                ST_LOW: begin
                    if (q_cls.is_rparen) begin
                        emit = 1'b1;
                        if (high_reg[8] || low_reg[8]) begin
                            emit_err = 1'b1;
                        end else begin
                            emit_port = {high_reg[7:0], low_reg[7:0]};
                        end
                        state_next = ST_WORD;
                        count_next = '0;
                        high_next  = '0;
                        low_next   = '0;
                    end else if (q_cls.is_digit) begin
                        low_next = frp_pkg::accumulate(low_reg, q_cls.digit);
                    end
                end
                default: begin
                    state_next = ST_WORD;
                    count_next = '0;
                    high_next  = '0;
                    low_next   = '0;
                end
            endcase
        end
    end

    // Result register: refilled on a pop that produces a result
    always_comb begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_port_next  = out_port_reg;
        out_err_next   = out_err_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        if (emit) begin
            out_valid_next = 1'b1;
            out_code_next  = emit_code;
            out_port_next  = emit_port;
            out_err_next   = emit_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WORD;
            passive_reg   <= 1'b0;
            count_reg     <= '0;
            digits_reg    <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            passive_reg   <= passive_next;
            count_reg     <= count_next;
            digits_reg    <= digits_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_code_reg <= out_code_next;
        out_port_reg <= out_port_next;
        out_err_reg  <= out_err_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_reply_code  = out_code_reg;
    assign m_data_port   = out_port_reg;
    assign m_parse_error = out_err_reg;

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_err_reg) |-> (out_code_reg == '0 && out_port_reg == '0))
        else $error("error result carries data");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_WORD) |-> (count_reg <= 3'd3))
        else $error("match count out of range");

endmodule

`default_nettype wire

@@ src/ftp_reply_parser_unit.sv @@
`default_nettype none

// FTP control reply parser. One reply byte is taken per request on the s_
// channel; at most one result per byte leaves on the m_ channel. With
// passive_mode = 0 (cfg_wr_data written via cfg_wr_en) the block captures the
// three-digit reply code, follows multi-line replies (code-dash opens, code-
// space marks the last line) and emits the code at the newline that ends the
// reply. With passive_mode = 1 it checks the first word is three characters,
// skips four commas, accumulates two decimal numbers and emits
// data_port = high*256 + low at the closing parenthesis. A first word that is
// not three characters (code mode: three digits), or a passive number
// above 255, gives a result with parse_error set and zero data. Writing the
// mode register clears the parser; write it only with no bytes in flight.
// Throughput is one byte per clock while the result register is free or
// being taken on m_; a byte accepted on s_ is written into the queue, and
// its result is loaded into the result register when the back end pops it.
// A two-entry queue between the classifying front end and the parsing back
// end, plus a result register, lets input and output stall independently.
module ftp_reply_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // reply bytes
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_reply_code,
    output logic [15:0]      m_data_port,
    output logic             m_parse_error
);

    logic                push;
    frp_pkg::frp_class_t push_cls;
    logic                q_full;
    logic                q_valid;
    frp_pkg::frp_class_t q_cls;
    logic                pop;

    // Front: handshake and byte classification
    frp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .push      (push),
        .push_cls  (push_cls)
    );

    // Decoupling queue
    frp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cls (push_cls),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cls    (q_cls),
        .pop      (pop)
    );

    // Back: parser state and result register
    frp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_cls         (q_cls),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reply_code  (m_reply_code),
        .m_data_port   (m_data_port),
        .m_parse_error (m_parse_error)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 8;          // extra settling wait at the end of drain()
    localparam int LONG_HOLD    = 400;        // receiver hold-off, in cycles
    localparam int LIMIT_CYCLES = 1_000_000;

    // mode register values
    localparam logic MODE_CODE    = 1'b0;
    localparam logic MODE_PASSIVE = 1'b1;

    // parser phases; meaning of 1..6 depends on mode
    localparam logic [2:0] PH_WORD   = 3'd0;  // first word / reply code
    localparam logic [2:0] PH_TAIL   = 3'd1;  // code: skip to newline
    localparam logic [2:0] PH_MATCH  = 3'd2;  // code: scan continuation lines
    localparam logic [2:0] PH_COMMA1 = 3'd1;  // passive: commas 1..4
    localparam logic [2:0] PH_COMMA4 = 3'd4;
    localparam logic [2:0] PH_HIGH   = 3'd5;  // passive: high port number
    localparam logic [2:0] PH_LOW    = 3'd6;  // passive: low port number

    localparam int NUM_CAP = 256;             // passive accumulators saturate here

    typedef struct {
        logic [9:0]  code;
        logic [15:0] port;
        logic        err;
    } reply_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [9:0]  m_reply_code;
    logic [15:0] m_data_port;
    logic        m_parse_error;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    ftp_reply_parser_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reply_code  (m_reply_code),
        .m_data_port   (m_data_port),
        .m_parse_error (m_parse_error)
    );

    // ------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------
    logic [7:0] byte_q[$];        // reply bytes waiting to be sent
    reply_t     replies_due[$];   // predicted results, oldest first

    int  mismatches     = 0;
    int  bytes_taken    = 0;
    int  results_seen   = 0;
    int  n_codes        = 0;
    int  n_ports        = 0;
    int  n_errors       = 0;
    int  in_stall_cycles = 0;
    int  cycles         = 0;
    bit  calm           = 1'b0;   // 1: no random idling on either side
    int  hold_asks      = 0;      // bumped to request one long receiver hold
    int  hold_seen      = 0;

    // ------------------------------------------------------------------
    // predictor: own copy of mode and parse state
    // ------------------------------------------------------------------
    logic        pasv_mode = MODE_CODE;
    logic [2:0]  prs_phase = PH_WORD;
    logic [2:0]  word_cnt  = 3'd0;   // first-word length, or continuation match count
    logic [11:0] code_nib  = 12'd0;  // three held digits, first digit lowest
    logic [9:0]  num_hi    = 10'd0;
    logic [9:0]  num_lo    = 10'd0;

    function automatic logic [9:0] dec_push(input logic [9:0] acc, input logic [3:0] d);
        int v;
        v = int'(acc) * 10 + int'(d);
        return (v > NUM_CAP) ? 10'(NUM_CAP) : 10'(v);
    endfunction

    task automatic restart_parse();
        prs_phase = PH_WORD;
        word_cnt  = 3'd0;
        num_hi    = 10'd0;
        num_lo    = 10'd0;
    endtask

    task automatic expect_reply(input int code_val, input int port, input logic err);
        replies_due.push_back('{10'(code_val), 16'(port), err});
        if (err)
            n_errors++;
        else if (pasv_mode == MODE_PASSIVE)
            n_ports++;
        else
            n_codes++;
    endtask

    // Advance the parser by one accepted byte, queueing any result it causes.
    task automatic parse_byte(input logic [7:0] c);
        logic       is_dig;
        logic [3:0] dval;
        logic       bad;
        int         code_val;
        is_dig = (c >= frp_pkg::CH_ZERO) && (c <= frp_pkg::CH_NINE);
        dval   = 4'(c - frp_pkg::CH_ZERO);

        // first word: same length check in both modes
        if (prs_phase == PH_WORD && c == frp_pkg::CH_SPACE) begin
            if (word_cnt != 3'd3) begin
                restart_parse();
                expect_reply(0, 0, 1'b1);
            end else begin
                word_cnt  = 3'd0;
                prs_phase = PH_TAIL;  // same value as PH_COMMA1
            end
        end else if (pasv_mode == MODE_CODE) begin
            case (prs_phase)
                PH_WORD: begin
                    if (c == frp_pkg::CH_DASH) begin
                        word_cnt  = 3'd0;
                        prs_phase = PH_MATCH;
                    end else if (is_dig) begin
                        // digits beyond the third are counted, not held
                        if (word_cnt < 3'd3)
                            code_nib[{word_cnt, 2'b00} +: 4] = dval;
                        if (word_cnt < 3'd7)
                            word_cnt++;
                    end
                end
                PH_TAIL: begin
                    if (c == frp_pkg::CH_NL) begin
                        code_val = int'(code_nib[3:0]) * 100 + int'(code_nib[7:4]) * 10
                                 + int'(code_nib[11:8]);
                        restart_parse();
                        expect_reply(code_val, 0, 1'b0);
                    end
                end
                PH_MATCH: begin
                    if (word_cnt < 3'd3 && is_dig && dval == code_nib[{word_cnt, 2'b00} +: 4])
                        word_cnt++;
                    else if (word_cnt == 3'd3 && c == frp_pkg::CH_SPACE) begin
                        word_cnt  = 3'd0;
                        prs_phase = PH_TAIL;
                    end else
                        word_cnt = 3'd0;   // any miss restarts the match
                end
                default: restart_parse();
            endcase
        end else begin
            case (prs_phase)
                PH_WORD: begin
                    // any non-space byte counts toward the first word
                    if (word_cnt < 3'd7)
                        word_cnt++;
                end
                PH_HIGH: begin
                    if (c == frp_pkg::CH_COMMA) begin
                        word_cnt  = 3'd0;
                        prs_phase = PH_LOW;
                    end else if (is_dig)
                        num_hi = dec_push(num_hi, dval);
                end
                PH_LOW: begin
                    if (c == frp_pkg::CH_RPAREN) begin
                        bad = (num_hi > 10'd255) || (num_lo > 10'd255);
                        code_val = bad ? 0 : int'(num_hi) * 256 + int'(num_lo);
                        restart_parse();
                        expect_reply(0, code_val, bad);
                    end else if (is_dig)
                        num_lo = dec_push(num_lo, dval);
                end
                default: begin
                    if (prs_phase >= PH_COMMA1 && prs_phase <= PH_COMMA4) begin
                        if (c == frp_pkg::CH_COMMA)
                            prs_phase = prs_phase + 3'd1;
                    end else
                        restart_parse();
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // idling: mostly none, some short gaps, a few long ones
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued bytes, predicts on each accepted request
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_taken++;
            end
            if (s_valid && !s_ready)
                in_stall_cycles++;
            // slot is free after this edge: idle a while or load the next byte
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= byte_q.pop_front();
                    send_gap  <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver ready: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    int take_gap  = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_gap  <= 0;
            hold_left <= 0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (take_gap != 0) begin
            take_gap <= take_gap - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready  <= 1'b1;
            take_gap <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string why, input reply_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: want code=%0d port=%0d err=%0b, got code=%0d port=%0d err=%0b",
                     $realtime, why, want.code, want.port, want.err,
                     m_reply_code, m_data_port, m_parse_error);
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                want = '{10'd0, 16'd0, 1'b0};
                log_mismatch("result with nothing pending", want);
            end else begin
                want = replies_due.pop_front();
                if (m_reply_code !== want.code || m_data_port !== want.port
                        || m_parse_error !== want.err)
                    log_mismatch("wrong result", want);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, replies_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    // Decimal number, sometimes with a leading zero.
    task automatic push_num(input int v);
        bit started;
        started = 1'b0;
        if ($urandom_range(9) == 0)
            byte_q.push_back(frp_pkg::CH_ZERO);
        for (int div = 10000; div >= 1; div /= 10) begin
            if ((v / div) != 0 || started || div == 1) begin
                byte_q.push_back(frp_pkg::CH_ZERO + 8'((v / div) % 10));
                started = 1'b1;
            end
        end
    endtask

    task automatic push_noise();
        repeat ($urandom_range(5, 1))
            byte_q.push_back(8'($urandom_range(255)));
    endtask

    // short printable text, may hold digits, dashes and spaces
    task automatic push_text();
        repeat ($urandom_range(6))
            byte_q.push_back(8'($urandom_range(8'h7E, 8'h20)));
    endtask

    // Passive port value: mostly legal, some above 255, some at the edges.
    function automatic int pick_port_num();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(255);
        if (r < 85)
            return ($urandom_range(1) != 0) ? 255 : 0;
        if (r < 95)
            return $urandom_range(999, 256);
        return $urandom_range(99999, 1000);
    endfunction

    // One code-mode reply: single or multi-line, or a broken/noisy one.
    task automatic add_code_reply();
        logic [7:0] d[3];
        int         kind;
        kind = $urandom_range(99);
        foreach (d[i])
            d[i] = frp_pkg::CH_ZERO + 8'($urandom_range(9));
        if (kind < 12) begin
            push_noise();
        end else if (kind < 20) begin
            // code word of the wrong length
            repeat (($urandom_range(1) != 0) ? $urandom_range(2) : $urandom_range(7, 4))
                byte_q.push_back(frp_pkg::CH_ZERO + 8'($urandom_range(9)));
            byte_q.push_back(frp_pkg::CH_SPACE);
            push_text();
            byte_q.push_back(frp_pkg::CH_NL);
        end else if (kind < 55) begin
            // multi-line: code-dash, continuation lines, code-space last line
            foreach (d[i])
                byte_q.push_back(d[i]);
            byte_q.push_back(frp_pkg::CH_DASH);
            push_text();
            byte_q.push_back(frp_pkg::CH_NL);
            repeat ($urandom_range(3)) begin
                case ($urandom_range(2))
                    0: begin   // repeated code with dash
                        foreach (d[i])
                            byte_q.push_back(d[i]);
                        byte_q.push_back(frp_pkg::CH_DASH);
                    end
                    1: begin   // partial code, then text (usually a miss)
                        byte_q.push_back(d[0]);
                        byte_q.push_back(d[1]);
                    end
                    default: ;
                endcase
                push_text();
                byte_q.push_back(frp_pkg::CH_NL);
            end
            foreach (d[i])
                byte_q.push_back(d[i]);
            byte_q.push_back(frp_pkg::CH_SPACE);
            push_text();
            byte_q.push_back(frp_pkg::CH_NL);
        end else begin
            foreach (d[i])
                byte_q.push_back(d[i]);
            byte_q.push_back(frp_pkg::CH_SPACE);
            push_text();
            byte_q.push_back(frp_pkg::CH_NL);
        end
    endtask

    // One passive reply: word, text, six numbers, closing parenthesis; or a broken one.
    task automatic add_pasv_reply();
        int kind;
        kind = $urandom_range(99);
        if (kind < 10) begin
            push_noise();
            return;
        end
        if (kind < 18) begin
            // first word of the wrong length
            repeat (($urandom_range(1) != 0) ? $urandom_range(2) : $urandom_range(7, 4))
                byte_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
            byte_q.push_back(frp_pkg::CH_SPACE);
            return;
        end
        if (kind < 70)
            push_str("227");
        else
            repeat (3) byte_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
        byte_q.push_back(frp_pkg::CH_SPACE);
        repeat ($urandom_range(4))
            byte_q.push_back(8'($urandom_range(8'h5A, 8'h41)));
        push_str("(");
        repeat (4) begin
            push_num($urandom_range(255));
            byte_q.push_back(frp_pkg::CH_COMMA);
        end
        push_num(pick_port_num());
        if ($urandom_range(9) == 0)
            push_str("x");    // stray non-digit inside a number
        byte_q.push_back(frp_pkg::CH_COMMA);
        push_num(pick_port_num());
        byte_q.push_back(frp_pkg::CH_RPAREN);
        if ($urandom_range(4) == 0)
            push_str(".\n");  // trailing text spoils the next first word
    endtask

    task automatic fill_code(input int n);
        @(negedge aclk);
        while (byte_q.size() < n)
            add_code_reply();
    endtask

    task automatic fill_pasv(input int n);
        @(negedge aclk);
        while (byte_q.size() < n)
            add_pasv_reply();
    endtask

    // Sender waits until every request is taken and every result is back.
    task automatic drain();
        while (byte_q.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mode write, only with the block idle; also clears the parser.
    task automatic set_mode(input logic v);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pasv_mode = v;
        code_nib  = 12'd0;
        restart_parse();
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // code mode, directed: long word with a non-digit, ignored extreme
        // bytes, dash after a short code, continuation miss, code 000
        set_mode(MODE_CODE);
        push_str("1x2345 ");
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        push_str("99-9x993 \n");
        push_str("000 \n");
        fill_code(400);

        // receiver holds off while the sender streams back to back
        drain();
        @(negedge aclk);
        calm = 1'b1;
        hold_asks++;
        fill_code(160);
        drain();
        calm = 1'b0;

        // passive mode, directed: max port, short word, empty numbers,
        // number above 255 with a stray letter
        set_mode(MODE_PASSIVE);
        push_str("227 ,,,,255,255)");
        push_str("12 ");
        push_str("9a7 ,,,,,)");
        push_str("227 ,,,,3x00,7)");
        fill_pasv(350);

        // no idling on either side for a stretch
        drain();
        @(negedge aclk);
        calm = 1'b1;
        fill_pasv(150);
        drain();
        calm = 1'b0;

        set_mode(MODE_CODE);
        fill_code(250);
        set_mode(MODE_PASSIVE);
        fill_pasv(200);
        drain();

        $display("Sent %0d reply bytes across code and passive modes; %0d results back",
                 bytes_taken, results_seen);
        $display("(%0d codes, %0d ports, %0d parse errors), input stalled %0d cycles.",
                 n_codes, n_ports, n_errors, in_stall_cycles);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, replies_due.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/frp_pkg.sv
src/frp_front.sv
src/frp_queue.sv
src/frp_back.sv
src/ftp_reply_parser_unit.sv
test/tb_top.sv
